// File: hw/rtl/spdpi_pkg.sv
// Shared types, widths, register codes and the symmetric clamp for the speed PI loop.
// No dependencies; every other file in hw/rtl uses it.
`default_nettype none

package spdpi_pkg;

    localparam int unsigned DIVIDE_DEF = 16;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned SPD_W      = 32;
    localparam int unsigned LIM_W      = 31;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned FRAC       = 16;
    localparam int unsigned ERR_W      = SPD_W + 1;
    localparam int unsigned PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int unsigned TERM_W     = PROD_W - FRAC;
    localparam int unsigned SUM_W      = TERM_W + 2;

    typedef enum logic [IDX_W-1:0] {
        REG_SPEED_CAP      = 3'd0,
        REG_RAMP_STEP      = 3'd1,
        REG_PROP_GAIN      = 3'd2,
        REG_BRAKE_GAIN     = 3'd3,
        REG_INTEG_GAIN_DT  = 3'd4,
        REG_INTEG_CAP      = 3'd5,
        REG_OUTPUT_LIMIT   = 3'd6,
        REG_FRICTION       = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [LIM_W-1:0] speed_cap;
        logic [LIM_W-1:0] ramp_step;
    } ramp_cfg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] brake_gain;
        logic [GAIN_W-1:0] integ_gain_dt;
    } gain_cfg_t;

    typedef struct packed {
        logic [LIM_W-1:0] integ_cap;
        logic [LIM_W-1:0] output_limit;
        logic [LIM_W-1:0] friction_current;
    } out_cfg_t;

    // ramp stage -> multiply stage
    typedef struct packed {
        logic [SPD_W-1:0] cmd;
        logic [SPD_W-1:0] meas;
        logic             upd;
    } ramp_req_t;

    // multiply stage -> output stage
    typedef struct packed {
        logic [TERM_W-1:0] p_term;
        logic [TERM_W-1:0] i_term;
        logic              pos;
        logic              neg;
        logic              brake;
        logic              upd;
    } term_req_t;

    function automatic logic signed [SUM_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-LIM_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/spdpi_ramp.sv
// Stage 1: target clamp, update divider and command ramp; holds the command speed state.
// Depends on spdpi_pkg.
`default_nettype none

module spdpi_ramp #(
    parameter int unsigned DIVIDE = spdpi_pkg::DIVIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output      logic                          up_ready,
    input  wire logic [spdpi_pkg::SPD_W-1:0]   measured_speed,
    input  wire logic [spdpi_pkg::SPD_W-1:0]   target_speed,
    input  wire spdpi_pkg::ramp_cfg_t          cfg,
    output      logic                          down_valid,
    input  wire logic                          down_ready,
    output      spdpi_pkg::ramp_req_t          down
);

    localparam int unsigned SW = spdpi_pkg::SUM_W;
    localparam int unsigned PW = spdpi_pkg::SPD_W;
    localparam int unsigned CW = spdpi_pkg::CNT_W;

    logic                   valid_reg;
    spdpi_pkg::ramp_req_t   data_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [PW-1:0]          cmd_reg;
    logic [PW-1:0]          cmd_next;
    logic [CW:0]            count_inc;
    logic                   upd;
    logic                   take;
    logic signed [SW-1:0]   tgt;
    logic signed [SW-1:0]   delta;
    logic signed [SW-1:0]   cmd_sum;

    assign up_ready   = !valid_reg || down_ready;
    assign take       = up_valid && up_ready;
    assign down_valid = valid_reg;
    assign down       = data_reg;

    always_comb
    begin
        count_inc  = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};
        upd        = count_inc >= (CW+1)'(DIVIDE);
        count_next = upd ? '0 : count_inc[CW-1:0];
        tgt        = spdpi_pkg::clamp_sym(
                         SW'($signed(target_speed)), cfg.speed_cap);
        delta      = spdpi_pkg::clamp_sym(
                         tgt - SW'($signed(cmd_reg)), cfg.ramp_step);
        cmd_sum    = SW'($signed(cmd_reg)) + delta;
        cmd_next   = upd ? cmd_sum[PW-1:0] : cmd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
            if (take)
            begin
                count_reg <= count_next;
                cmd_reg   <= cmd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.cmd  <= cmd_next;
            data_reg.meas <= measured_speed;
            data_reg.upd  <= upd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spdpi_mult.sv
// Stage 2: speed error, brake detect, gain select and the two gain products (>>16).
// Depends on spdpi_pkg.
`default_nettype none

module spdpi_mult (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  up_valid,
    output      logic                  up_ready,
    input  wire spdpi_pkg::ramp_req_t  up,
    input  wire spdpi_pkg::gain_cfg_t  cfg,
    output      logic                  down_valid,
    input  wire logic                  down_ready,
    output      spdpi_pkg::term_req_t  down
);

    localparam int unsigned EW = spdpi_pkg::ERR_W;
    localparam int unsigned MW = spdpi_pkg::PROD_W;
    localparam int unsigned GW = spdpi_pkg::GAIN_W;
    localparam int unsigned FR = spdpi_pkg::FRAC;

    logic                   valid_reg;
    spdpi_pkg::term_req_t   data_reg;
    logic                   take;
    logic signed [EW-1:0]   err;
    logic                   pos;
    logic                   neg;
    logic                   brake;
    logic [GW-1:0]          gain;
    logic signed [MW-1:0]   p_prod;
    logic signed [MW-1:0]   i_prod;

    assign up_ready   = !valid_reg || down_ready;
    assign take       = up_valid && up_ready;
    assign down_valid = valid_reg;
    assign down       = data_reg;

    always_comb
    begin
        err    = EW'($signed(up.cmd)) - EW'($signed(up.meas));
        pos    = !up.cmd[$bits(up.cmd)-1] && (|up.cmd);
        neg    = up.cmd[$bits(up.cmd)-1];
        brake  = (pos && err[EW-1]) || (neg && !err[EW-1] && (|err));
        gain   = brake ? cfg.brake_gain : cfg.prop_gain;
        p_prod = $signed({1'b0, gain}) * err;
        i_prod = $signed({1'b0, cfg.integ_gain_dt}) * err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.p_term <= p_prod[MW-1:FR];
            data_reg.i_term <= i_prod[MW-1:FR];
            data_reg.pos    <= pos;
            data_reg.neg    <= neg;
            data_reg.brake  <= brake;
            data_reg.upd    <= up.upd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spdpi_out.sv
// Stage 3: integral accumulate and clamp, feedforward, brake zeroing, output clamp, result register.
// Depends on spdpi_pkg.
`default_nettype none

module spdpi_out (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         up_valid,
    output      logic                         up_ready,
    input  wire spdpi_pkg::term_req_t         up,
    input  wire spdpi_pkg::out_cfg_t          cfg,
    output      logic                         result_valid,
    input  wire logic                         result_ready,
    output      logic [spdpi_pkg::SPD_W-1:0]  current_ref,
    output      logic                         updated,
    output      logic                         saturated
);

    localparam int unsigned SW = spdpi_pkg::SUM_W;
    localparam int unsigned PW = spdpi_pkg::SPD_W;
    localparam int unsigned LW = spdpi_pkg::LIM_W;

    logic                   valid_reg;
    logic [PW-1:0]          integral_reg;
    logic [PW-1:0]          ref_reg;
    logic                   sat_reg;
    logic                   upd_reg;
    logic                   take;
    logic signed [SW-1:0]   integ;
    logic signed [SW-1:0]   ff;
    logic signed [SW-1:0]   y;
    logic signed [SW-1:0]   y_lim;

    assign up_ready     = !valid_reg || result_ready;
    assign take         = up_valid && up_ready;
    assign result_valid = valid_reg;
    assign current_ref  = ref_reg;
    assign updated      = upd_reg;
    assign saturated    = sat_reg;

    always_comb
    begin
        integ = spdpi_pkg::clamp_sym(
                    SW'($signed(integral_reg)) + SW'($signed(up.i_term)),
                    cfg.integ_cap);
        if (up.pos)
        begin
            ff = $signed({{(SW-LW){1'b0}}, cfg.friction_current});
        end
        else if (up.neg)
        begin
            ff = -$signed({{(SW-LW){1'b0}}, cfg.friction_current});
        end
        else
        begin
            ff = '0;
        end
        y = SW'($signed(up.p_term)) + integ + ff;
        // braking never pushes further along the command direction
        if (up.brake && ((up.pos && (y > 0)) || (up.neg && (y < 0))))
        begin
            y = '0;
        end
        y_lim = spdpi_pkg::clamp_sym(y, cfg.output_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            integral_reg <= '0;
            ref_reg      <= '0;
            sat_reg      <= 1'b0;
            upd_reg      <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                valid_reg <= up_valid;
            end
            if (take)
            begin
                upd_reg <= up.upd;
                if (up.upd)
                begin
                    integral_reg <= integ[PW-1:0];
                    ref_reg      <= y_lim[PW-1:0];
                    sat_reg      <= (y_lim != y);
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/speed_pi_loop_with_ramp_unit.sv
// Top level of the speed PI loop: configuration registers and the three-stage datapath.
// Depends on spdpi_pkg, spdpi_ramp, spdpi_mult, spdpi_out.
//
// One sample request is taken per clock; its result is registered in the ramp, product and
// output stage registers in turn and can be taken once it sits in the output register. The
// rate is one sample per cycle, limited only by result_ready backpressure through the
// valid/ready chain of the three stage registers. Every DIVIDE-th sample recomputes the
// loop: the ramp stage owns the command speed, the product stage forms both gain terms,
// the output stage owns the integral and the held output. Other samples return the held
// current_ref with updated low. Configuration writes are always accepted and must be made
// while no sample is in flight.
`default_nettype none

module speed_pi_loop_with_ramp_unit #(
    parameter int unsigned DIVIDE = spdpi_pkg::DIVIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [spdpi_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [spdpi_pkg::SPD_W-1:0]   cfg_data,
    input  wire logic                          sample_valid,
    output      logic                          sample_ready,
    input  wire logic [spdpi_pkg::SPD_W-1:0]   measured_speed,
    input  wire logic [spdpi_pkg::SPD_W-1:0]   target_speed,
    output      logic                          result_valid,
    input  wire logic                          result_ready,
    output      logic [spdpi_pkg::SPD_W-1:0]   current_ref,
    output      logic                          updated,
    output      logic                          saturated
);

    localparam int unsigned LW = spdpi_pkg::LIM_W;
    localparam int unsigned GW = spdpi_pkg::GAIN_W;

    spdpi_pkg::ramp_cfg_t   ramp_cfg_reg;
    spdpi_pkg::gain_cfg_t   gain_cfg_reg;
    spdpi_pkg::out_cfg_t    out_cfg_reg;
    logic                   s1_valid;
    logic                   s1_ready;
    spdpi_pkg::ramp_req_t   s1_data;
    logic                   s2_valid;
    logic                   s2_ready;
    spdpi_pkg::term_req_t   s2_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_cfg_reg <= '0;
            gain_cfg_reg <= '0;
            out_cfg_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (spdpi_pkg::cfg_reg_t'(cfg_index))
                spdpi_pkg::REG_SPEED_CAP:      ramp_cfg_reg.speed_cap        <= cfg_data[LW-1:0];
                spdpi_pkg::REG_RAMP_STEP:      ramp_cfg_reg.ramp_step        <= cfg_data[LW-1:0];
                spdpi_pkg::REG_PROP_GAIN:      gain_cfg_reg.prop_gain        <= cfg_data[GW-1:0];
                spdpi_pkg::REG_BRAKE_GAIN:     gain_cfg_reg.brake_gain       <= cfg_data[GW-1:0];
                spdpi_pkg::REG_INTEG_GAIN_DT:  gain_cfg_reg.integ_gain_dt    <= cfg_data[GW-1:0];
                spdpi_pkg::REG_INTEG_CAP:      out_cfg_reg.integ_cap         <= cfg_data[LW-1:0];
                spdpi_pkg::REG_OUTPUT_LIMIT:   out_cfg_reg.output_limit      <= cfg_data[LW-1:0];
                spdpi_pkg::REG_FRICTION:       out_cfg_reg.friction_current  <= cfg_data[LW-1:0];
            endcase
        end
    end

    spdpi_ramp #(
        .DIVIDE (DIVIDE)
    ) u_ramp (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (sample_valid),
        .up_ready       (sample_ready),
        .measured_speed (measured_speed),
        .target_speed   (target_speed),
        .cfg            (ramp_cfg_reg),
        .down_valid     (s1_valid),
        .down_ready     (s1_ready),
        .down           (s1_data)
    );

    spdpi_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s1_ready),
        .up         (s1_data),
        .cfg        (gain_cfg_reg),
        .down_valid (s2_valid),
        .down_ready (s2_ready),
        .down       (s2_data)
    );

    spdpi_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (s2_valid),
        .up_ready     (s2_ready),
        .up           (s2_data),
        .cfg          (out_cfg_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .current_ref  (current_ref),
        .updated      (updated),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for speed_pi_loop_with_ramp_unit: drives sample requests through a fixed opening
// setting and random settings and checks every result against a cycle-free model of the loop.
// Depends on spdpi_pkg and speed_pi_loop_with_ramp_unit.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [spdpi_pkg::SPD_W-1:0] meas;
        logic [spdpi_pkg::SPD_W-1:0] tgt;
    } speed_sample_t;

    typedef struct {
        logic [spdpi_pkg::SPD_W-1:0] cur;
        logic                        upd;
        logic                        sat;
    } loop_out_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    spdpi_pkg::cfg_reg_t         cfg_index = spdpi_pkg::REG_SPEED_CAP;
    logic [spdpi_pkg::SPD_W-1:0] cfg_data = '0;
    logic                        sample_valid = 1'b0;
    logic                        sample_ready;
    logic [spdpi_pkg::SPD_W-1:0] measured_speed = '0;
    logic [spdpi_pkg::SPD_W-1:0] target_speed = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    logic [spdpi_pkg::SPD_W-1:0] current_ref;
    logic                        updated;
    logic                        saturated;

    speed_pi_loop_with_ramp_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .measured_speed (measured_speed),
        .target_speed   (target_speed),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .current_ref    (current_ref),
        .updated        (updated),
        .saturated      (saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model copy of registers and loop state
    spdpi_pkg::ramp_cfg_t                ramp_cfg = '0;
    spdpi_pkg::gain_cfg_t                gain_cfg = '0;
    spdpi_pkg::out_cfg_t                 out_cfg = '0;
    logic [spdpi_pkg::CNT_W-1:0]         samples_since_update = '0;
    logic signed [spdpi_pkg::SPD_W-1:0]  cmd_speed = '0;
    logic signed [spdpi_pkg::SPD_W-1:0]  integ_acc = '0;
    logic [spdpi_pkg::SPD_W-1:0]         held_cur = '0;
    logic                                held_sat = 1'b0;

    speed_sample_t samples_to_send[$];
    loop_out_t     results_due[$];
    logic [spdpi_pkg::SPD_W-1:0] reg_plan [8];

    logic  sample_taken = 1'b0;
    logic  cfg_taken = 1'b0;
    logic  result_taken = 1'b0;
    int    send_gap_max = 0;
    int    recv_stall_max = 0;
    int    gap_left = 0;
    int    stall_left = 0;
    int    err_count = 0;
    int    samples_in = 0;
    int    updates_out = 0;
    int    sat_out = 0;
    int    cfg_writes = 0;
    int    settings_used = 0;
    speed_sample_t nxt;

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic void apply_reg(input spdpi_pkg::cfg_reg_t idx,
                                      input logic [spdpi_pkg::SPD_W-1:0] data);
        case (idx)
            spdpi_pkg::REG_SPEED_CAP:     ramp_cfg.speed_cap = data[spdpi_pkg::LIM_W-1:0];
            spdpi_pkg::REG_RAMP_STEP:     ramp_cfg.ramp_step = data[spdpi_pkg::LIM_W-1:0];
            spdpi_pkg::REG_PROP_GAIN:     gain_cfg.prop_gain = data[spdpi_pkg::GAIN_W-1:0];
            spdpi_pkg::REG_BRAKE_GAIN:    gain_cfg.brake_gain = data[spdpi_pkg::GAIN_W-1:0];
            spdpi_pkg::REG_INTEG_GAIN_DT:
                gain_cfg.integ_gain_dt = data[spdpi_pkg::GAIN_W-1:0];
            spdpi_pkg::REG_INTEG_CAP:     out_cfg.integ_cap = data[spdpi_pkg::LIM_W-1:0];
            spdpi_pkg::REG_OUTPUT_LIMIT:  out_cfg.output_limit = data[spdpi_pkg::LIM_W-1:0];
            spdpi_pkg::REG_FRICTION:
                out_cfg.friction_current = data[spdpi_pkg::LIM_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void speed_loop_step(input logic [spdpi_pkg::SPD_W-1:0] meas_w,
                                            input logic [spdpi_pkg::SPD_W-1:0] tgt_w);
        longint meas;
        longint tgt;
        longint cmd;
        longint err;
        longint integ;
        longint ff;
        longint y;
        longint y_lim;
        logic   brake;
        logic [spdpi_pkg::GAIN_W-1:0] gain;
        loop_out_t o;
        meas = longint'($signed(meas_w));
        tgt = clip(longint'($signed(tgt_w)), longint'(ramp_cfg.speed_cap));
        if (int'(samples_since_update) + 1 < int'(spdpi_pkg::DIVIDE_DEF))
        begin
            samples_since_update = samples_since_update + 1'b1;
            o.upd = 1'b0;
        end
        else
        begin
            samples_since_update = '0;
            cmd = longint'(cmd_speed);
            cmd = cmd + clip(tgt - cmd, longint'(ramp_cfg.ramp_step));
            cmd_speed = cmd[spdpi_pkg::SPD_W-1:0];
            err = cmd - meas;
            integ = longint'(integ_acc)
                    + ((longint'(gain_cfg.integ_gain_dt) * err) >>> spdpi_pkg::FRAC);
            integ = clip(integ, longint'(out_cfg.integ_cap));
            integ_acc = integ[spdpi_pkg::SPD_W-1:0];
            ff = 0;
            if (cmd > 0)
            begin
                ff = longint'(out_cfg.friction_current);
            end
            else if (cmd < 0)
            begin
                ff = -longint'(out_cfg.friction_current);
            end
            brake = (cmd > 0 && err < 0) || (cmd < 0 && err > 0);
            gain = brake ? gain_cfg.brake_gain : gain_cfg.prop_gain;
            y = ((longint'(gain) * err) >>> spdpi_pkg::FRAC) + integ + ff;
            if (brake && ((y > 0 && cmd > 0) || (y < 0 && cmd < 0)))
            begin
                y = 0;
            end
            y_lim = clip(y, longint'(out_cfg.output_limit));
            held_cur = y_lim[spdpi_pkg::SPD_W-1:0];
            held_sat = (y_lim != y);
            o.upd = 1'b1;
        end
        o.cur = held_cur;
        o.sat = held_sat;
        results_due.push_back(o);
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [spdpi_pkg::SPD_W-1:0] got,
                                   input logic [spdpi_pkg::SPD_W-1:0] want);
        if (err_count < 30)
        begin
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        err_count++;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else if (!sample_valid || sample_taken)
        begin
            if (sample_valid)
            begin
                gap_left = $urandom_range(0, send_gap_max);
            end
            if (gap_left == 0 && samples_to_send.size() != 0)
            begin
                nxt = samples_to_send.pop_front();
                measured_speed <= nxt.meas;
                target_speed <= nxt.tgt;
                sample_valid <= 1'b1;
            end
            else
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                sample_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (result_taken)
        begin
            stall_left = $urandom_range(0, recv_stall_max);
        end
        if (stall_left != 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_taken <= 1'b0;
            cfg_taken <= 1'b0;
            result_taken <= 1'b0;
        end
        else
        begin
            sample_taken <= sample_valid && sample_ready;
            cfg_taken <= cfg_valid && cfg_ready;
            result_taken <= result_valid && result_ready;
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (result_valid && result_ready)
            begin
                if (results_due.size() == 0)
                begin
                    report_mismatch("unexpected result", current_ref, '0);
                end
                else
                begin
                    if (current_ref !== results_due[0].cur)
                    begin
                        report_mismatch("current_ref", current_ref, results_due[0].cur);
                    end
                    if (updated !== results_due[0].upd)
                    begin
                        report_mismatch("updated", updated, results_due[0].upd);
                    end
                    if (saturated !== results_due[0].sat)
                    begin
                        report_mismatch("saturated", saturated, results_due[0].sat);
                    end
                    updates_out += results_due[0].upd;
                    sat_out += results_due[0].upd & results_due[0].sat;
                    void'(results_due.pop_front());
                end
            end
            if (sample_valid && sample_ready)
            begin
                speed_loop_step(measured_speed, target_speed);
                samples_in++;
            end
        end
    end

    task automatic write_reg(input spdpi_pkg::cfg_reg_t idx,
                             input logic [spdpi_pkg::SPD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(negedge clk);
        end
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (samples_to_send.size() != 0 || sample_valid || results_due.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    // 0 typical, 1 all ones, 2 zero limits, 3 noise, 4 fixed opening setting
    task automatic load_settings(input int mode);
        case (mode)
            0:
            begin
                reg_plan[spdpi_pkg::REG_SPEED_CAP]     = 32'($urandom_range(1, 2000)) << 16;
                reg_plan[spdpi_pkg::REG_RAMP_STEP]     = (32'($urandom_range(1, 200)) << 16)
                                                         + $urandom_range(0, 65535);
                reg_plan[spdpi_pkg::REG_PROP_GAIN]     = $urandom_range(0, 32'h4_0000);
                reg_plan[spdpi_pkg::REG_BRAKE_GAIN]    = $urandom_range(0, 32'h4_0000);
                reg_plan[spdpi_pkg::REG_INTEG_GAIN_DT] = $urandom_range(0, 32'h8000);
                reg_plan[spdpi_pkg::REG_INTEG_CAP]     = 32'($urandom_range(0, 100)) << 16;
                reg_plan[spdpi_pkg::REG_OUTPUT_LIMIT]  = 32'($urandom_range(1, 150)) << 16;
                reg_plan[spdpi_pkg::REG_FRICTION]      = $urandom_range(0, 32'h3_0000);
            end
            1:
            begin
                foreach (reg_plan[i])
                begin
                    reg_plan[i] = 32'hFFFF_FFFF;
                end
            end
            2:
            begin
                foreach (reg_plan[i])
                begin
                    reg_plan[i] = $urandom();
                end
                reg_plan[spdpi_pkg::REG_INTEG_CAP]    = '0;
                reg_plan[spdpi_pkg::REG_OUTPUT_LIMIT] = '0;
                reg_plan[spdpi_pkg::REG_SPEED_CAP]    = $urandom_range(0, 1) ? '0
                                                                              : 32'h0100_0000;
            end
            3:
            begin
                foreach (reg_plan[i])
                begin
                    reg_plan[i] = $urandom();
                end
            end
            default:
            begin
                reg_plan[spdpi_pkg::REG_SPEED_CAP]     = 32'h8064_0000;
                reg_plan[spdpi_pkg::REG_RAMP_STEP]     = 32'h000A_0000;
                reg_plan[spdpi_pkg::REG_PROP_GAIN]     = 32'hFF02_0000;
                reg_plan[spdpi_pkg::REG_BRAKE_GAIN]    = 32'h0000_8000;
                reg_plan[spdpi_pkg::REG_INTEG_GAIN_DT] = 32'h0000_4000;
                reg_plan[spdpi_pkg::REG_INTEG_CAP]     = 32'h0014_0000;
                reg_plan[spdpi_pkg::REG_OUTPUT_LIMIT]  = 32'h001E_0000;
                reg_plan[spdpi_pkg::REG_FRICTION]      = 32'h0001_8000;
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            write_reg(spdpi_pkg::cfg_reg_t'(i), reg_plan[i]);
        end
        settings_used++;
    endtask

    function automatic logic [spdpi_pkg::SPD_W-1:0] extreme_word(input int k);
        case (k % 6)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    initial
    begin
        int modes [9];
        int sent;
        int seg_len;
        logic [spdpi_pkg::SPD_W-1:0] tgt;
        speed_sample_t s;
        modes = '{0, 1, 2, 3, 0, 0, 3, 1, 0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_settings(4);
        for (int i = 0; i < 24; i++)
        begin
            s.meas = extreme_word(i);
            s.tgt = extreme_word(i / 6 + i + 1);
            samples_to_send.push_back(s);
        end
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            send_gap_max = (p % 3 == 0) ? 0 : 9;
            recv_stall_max = (p % 3 == 1) ? 0 : 9;
            load_settings(modes[p]);
            sent = 0;
            while (sent < 150)
            begin
                seg_len = 16 * $urandom_range(1, 3);
                case ($urandom_range(0, 5))
                    0: tgt = $urandom();
                    1: tgt = '0;
                    2: tgt = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: tgt = (($urandom_range(0, 1200) - 600) << 16)
                                   + $urandom_range(0, 65535);
                endcase
                for (int k = 0; k < seg_len; k++)
                begin
                    s.tgt = tgt;
                    case ($urandom_range(0, 7))
                        0: s.meas = $urandom();
                        1: s.meas = tgt;
                        default: s.meas = tgt + $urandom_range(0, 2 ** 21) - 2 ** 20;
                    endcase
                    samples_to_send.push_back(s);
                end
                sent += seg_len;
                if ($urandom_range(0, 3) == 0)
                begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        $display("run covered %0d samples, %0d loop updates (%0d clamped at the output)",
                 samples_in, updates_out, sat_out);
        $display("%0d register writes across %0d settings, %0d mismatches",
                 cfg_writes, settings_used, err_count);
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/spdpi_pkg.sv
hw/rtl/spdpi_ramp.sv
hw/rtl/spdpi_mult.sv
hw/rtl/spdpi_out.sv
hw/rtl/speed_pi_loop_with_ramp_unit.sv
dv/tb.sv
